/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BPM_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BPM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bpm_pkg.sv */
package bpm_pkg;

   localparam int BPM_ENTRIES   = 16;
   localparam int BPM_KEY_BITS  = 32;
   localparam int BPM_PIN_BITS  = 8;
   localparam int BPM_SLOT_BITS = $clog2(BPM_ENTRIES);
   localparam int BPM_CNT_BITS  = $clog2(BPM_ENTRIES + 1);
   localparam int BPM_MAX_BITS  = 5;
   localparam logic [BPM_MAX_BITS-1:0] BPM_MAX_RESET = BPM_MAX_BITS'(16);

   typedef logic [BPM_SLOT_BITS-1:0] bpm_slot_type;
   typedef logic [BPM_KEY_BITS-1:0]  bpm_key_type;
   typedef logic [BPM_PIN_BITS-1:0]  bpm_pins_type;
   typedef logic [BPM_CNT_BITS-1:0]  bpm_cnt_type;

   typedef enum logic [1:0] {
      OP_PIN   = 2'd0,
      OP_UNPIN = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } bpm_op_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_FILLED   = 3'd1,
      ST_REPLACED = 3'd2,
      ST_RELEASED = 3'd3,
      ST_ABSENT   = 3'd4,
      ST_NO_FREE  = 3'd5
   } bpm_status_type;

   typedef struct packed {
      bpm_op_type  req_type;
      bpm_key_type file_key;
   } bpm_req_type;

   typedef struct packed {
      bpm_status_type status;
      bpm_slot_type   slot;
      logic           writeback;
      bpm_key_type    writeback_key;
      bpm_pins_type   pins_after;
      logic           dirty_after;
   } bpm_rsp_type;

   // lookup results handed to the update logic
   typedef struct packed {
      logic         hit;
      bpm_slot_type hit_idx;
      logic         any_free;
      bpm_slot_type head_idx;
   } bpm_look_type;

endpackage

/* rtl/core/bpm_lookup.sv */
module bpm_lookup import bpm_pkg::*; (
   input  bpm_key_type              file_key,
   input  logic [BPM_ENTRIES-1:0]   valid,
   input  logic [BPM_ENTRIES-1:0]   in_fifo,
   input  bpm_key_type              keys [BPM_ENTRIES],
   input  bpm_slot_type             rank [BPM_ENTRIES],
   output bpm_look_type             look
);

   // Key match over all slots, lowest index wins; free-list head is the
   // unpinned slot at rank zero.
   always_comb begin
      look          = '0;
      look.any_free = |in_fifo;
      for (int i = BPM_ENTRIES - 1; i >= 0; i--) begin
         if (valid[i] && (keys[i] == file_key)) begin
            look.hit     = 1'b1;
            look.hit_idx = BPM_SLOT_BITS'(i);
         end
         if (in_fifo[i] && (rank[i] == '0)) begin
            look.head_idx = BPM_SLOT_BITS'(i);
         end
      end
   end

endmodule

/* rtl/core/bpm_pool.sv */
module bpm_pool import bpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  bpm_req_type req,
   input  bpm_cnt_type limit,
   output bpm_rsp_type rsp
);

   bpm_key_type              key_ff   [BPM_ENTRIES];
   bpm_key_type              key_in   [BPM_ENTRIES];
   bpm_pins_type             pins_ff  [BPM_ENTRIES];
   bpm_pins_type             pins_in  [BPM_ENTRIES];
   bpm_slot_type             rank_ff  [BPM_ENTRIES];
   bpm_slot_type             rank_in  [BPM_ENTRIES];
   logic [BPM_ENTRIES-1:0]   valid_ff, valid_in;
   logic [BPM_ENTRIES-1:0]   pinned_ff, pinned_in;
   logic [BPM_ENTRIES-1:0]   dirty_ff, dirty_in;
   bpm_cnt_type              free_count_ff, free_count_in;
   bpm_cnt_type              used_count_ff, used_count_in;

   logic [BPM_ENTRIES-1:0]   in_fifo;
   bpm_look_type             look;

   bpm_slot_type             sel;
   logic                     room;
   logic                     sel_pinned, sel_dirty;
   bpm_pins_type             sel_pins, pins_inc, pins_dec;
   bpm_slot_type             sel_rank;
   bpm_key_type              sel_key;
   logic                     do_fill, do_new, do_hitpin, do_unpin, do_mark, do_remove;
   logic                     append;

   // a slot sits on the free list exactly when it is valid and unpinned
   assign in_fifo = valid_ff & ~pinned_ff;

   bpm_lookup u_lookup (
      .file_key (req.file_key),
      .valid    (valid_ff),
      .in_fifo  (in_fifo),
      .keys     (key_ff),
      .rank     (rank_ff),
      .look     (look)
   );

   always_comb begin
      room = used_count_ff < limit;
      if (look.hit) begin
         sel = look.hit_idx;
      end else if (room) begin
         sel = used_count_ff[BPM_SLOT_BITS-1:0];
      end else begin
         sel = look.head_idx;
      end

      sel_pinned = pinned_ff[sel];
      sel_dirty  = dirty_ff[sel];
      sel_pins   = pins_ff[sel];
      sel_rank   = rank_ff[sel];
      sel_key    = key_ff[sel];
      pins_inc   = (sel_pins == '1) ? sel_pins : BPM_PIN_BITS'(sel_pins + 1'b1);
      pins_dec   = (sel_pins == '0) ? sel_pins : BPM_PIN_BITS'(sel_pins - 1'b1);

      do_fill   = 1'b0;
      do_new    = 1'b0;
      do_hitpin = 1'b0;
      do_unpin  = 1'b0;
      do_mark   = 1'b0;
      do_remove = 1'b0;
      rsp        = '0;
      rsp.status = ST_ABSENT;
      if (look.hit) begin
         rsp.slot        = sel;
         rsp.pins_after  = sel_pins;
         rsp.dirty_after = sel_dirty;
      end

      unique case (req.req_type)
         OP_PIN: begin
            if (look.hit) begin
               do_hitpin       = 1'b1;
               do_remove       = !sel_pinned;
               rsp.status      = ST_HIT;
               rsp.pins_after  = pins_inc;
            end else if (room) begin
               do_fill         = 1'b1;
               do_new          = 1'b1;
               rsp.status      = ST_FILLED;
               rsp.slot        = sel;
               rsp.pins_after  = BPM_PIN_BITS'(1);
            end else if (look.any_free) begin
               // evict the oldest unpinned slot
               do_fill           = 1'b1;
               do_remove         = 1'b1;
               rsp.status        = ST_REPLACED;
               rsp.slot          = sel;
               rsp.writeback     = sel_dirty;
               rsp.writeback_key = sel_dirty ? sel_key : '0;
               rsp.pins_after    = BPM_PIN_BITS'(1);
            end else begin
               rsp.status = ST_NO_FREE;
            end
         end
         OP_UNPIN: begin
            if (look.hit && sel_pinned) begin
               do_unpin       = 1'b1;
               rsp.status     = ST_RELEASED;
               rsp.pins_after = pins_dec;
            end
         end
         OP_READ, OP_WRITE: begin
            if (look.hit && sel_pinned) begin
               do_mark         = (req.req_type == OP_WRITE);
               rsp.status      = ST_HIT;
               rsp.dirty_after = sel_dirty | do_mark;
            end
         end
         default: begin
            rsp.status = ST_ABSENT;
         end
      endcase
   end

   assign append = do_unpin && (pins_dec == '0);

   always_comb begin
      for (int i = 0; i < BPM_ENTRIES; i++) begin
         key_in[i]    = key_ff[i];
         pins_in[i]   = pins_ff[i];
         rank_in[i]   = rank_ff[i];
         valid_in[i]  = valid_ff[i];
         pinned_in[i] = pinned_ff[i];
         dirty_in[i]  = dirty_ff[i];
         if (go) begin
            // close the gap left by the slot leaving the free list
            if (do_remove && in_fifo[i] && (rank_ff[i] > sel_rank)) begin
               rank_in[i] = BPM_SLOT_BITS'(rank_ff[i] - 1'b1);
            end
            if (sel == BPM_SLOT_BITS'(i)) begin
               if (do_fill) begin
                  key_in[i]    = req.file_key;
                  valid_in[i]  = 1'b1;
                  pinned_in[i] = 1'b1;
                  dirty_in[i]  = 1'b0;
                  pins_in[i]   = BPM_PIN_BITS'(1);
               end
               if (do_hitpin) begin
                  pinned_in[i] = 1'b1;
                  pins_in[i]   = pins_inc;
               end
               if (do_unpin) begin
                  pins_in[i] = pins_dec;
               end
               if (append) begin
                  pinned_in[i] = 1'b0;
                  rank_in[i]   = free_count_ff[BPM_SLOT_BITS-1:0];
               end
               if (do_mark) begin
                  dirty_in[i] = 1'b1;
               end
            end
         end
      end

      free_count_in = free_count_ff;
      used_count_in = used_count_ff;
      if (go) begin
         if (append) begin
            free_count_in = BPM_CNT_BITS'(free_count_ff + 1'b1);
         end else if (do_remove) begin
            free_count_in = BPM_CNT_BITS'(free_count_ff - 1'b1);
         end
         if (do_new) begin
            used_count_in = BPM_CNT_BITS'(used_count_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BPM_ENTRIES; i++) begin
         key_ff[i]  <= key_in[i];
         rank_ff[i] <= rank_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pinned_ff     <= '0;
         dirty_ff      <= '0;
         free_count_ff <= '0;
         used_count_ff <= '0;
         for (int i = 0; i < BPM_ENTRIES; i++) begin
            pins_ff[i] <= '0;
         end
      end else begin
         valid_ff      <= valid_in;
         pinned_ff     <= pinned_in;
         dirty_ff      <= dirty_in;
         free_count_ff <= free_count_in;
         used_count_ff <= used_count_in;
         for (int i = 0; i < BPM_ENTRIES; i++) begin
            pins_ff[i] <= pins_in[i];
         end
      end
   end

endmodule

/* rtl/core/pinned_buffer_pool_manager_unit.sv */
// A request word passes from the request register to the response register.
// Throughput: one request per cycle unless the response output stalls; the slot lookup
// and state update are combinational, between the request and response registers.
// Reset (synchronous, active high) empties the pool and the free list and sets
// the slot cap to 16; slot keys and free-list ranks are not cleared.
`include "assert_macros.svh"

module pinned_buffer_pool_manager_unit import bpm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bpm_req_type             req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bpm_rsp_type             rsp_data,
   input  logic                    csr_write,
   input  logic [BPM_MAX_BITS-1:0] csr_data
);

   logic [BPM_MAX_BITS-1:0] slot_cap_ff;
   logic                    in_valid_ff;
   bpm_req_type             in_data_ff;
   logic                    rsp_valid_ff;
   bpm_rsp_type             rsp_data_ff;
   logic                    out_ready;
   logic                    go;
   bpm_cnt_type             limit;
   bpm_rsp_type             result;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (int'(slot_cap_ff) < BPM_ENTRIES) begin
         limit = BPM_CNT_BITS'(slot_cap_ff);
      end else begin
         limit = BPM_CNT_BITS'(BPM_ENTRIES);
      end
   end

   bpm_pool u_pool (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .req   (in_data_ff),
      .limit (limit),
      .rsp   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_cap_ff  <= BPM_MAX_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            slot_cap_ff <= csr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (go) begin
         rsp_data_ff <= result;
      end
   end

   `BPM_ASSERT_NEXT(a_go_gives_rsp, clock, reset, go, rsp_valid_ff,
      "accepted request did not produce a response word")
   `BPM_ASSERT_IMPLY(a_wb_only_replace, clock, reset, rsp_valid_ff && rsp_data_ff.writeback,
      rsp_data_ff.status == ST_REPLACED, "writeback without replacement")
   `BPM_ASSERT_IMPLY(a_no_free_clean, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == ST_NO_FREE),
      (rsp_data_ff.slot == '0) && (rsp_data_ff.pins_after == '0),
      "no-free response carries slot data")
   `BPM_ASSERT_IMPLY(a_pinned_has_pins, clock, reset,
      rsp_valid_ff && ((rsp_data_ff.status == ST_FILLED) ||
      (rsp_data_ff.status == ST_REPLACED) ||
      ((rsp_data_ff.status == ST_HIT) && (rsp_data_ff.pins_after == '0) == 1'b0)),
      rsp_data_ff.pins_after != '0, "pinned slot reports zero pins")

endmodule
